// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Depends on nothing; the including module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/wtvm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the word tokenizer.
// No dependencies.
package wtvm_pkg;

  localparam int VOCAB_ENTRIES_DEF     = 256;
  localparam int MAX_TOKENS_DEF        = 12;
  localparam int WORD_BUFFER_BYTES_DEF = 32;

  // Input modes
  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_EOT  = 2'd1;
  localparam logic [1:0] MODE_VBYTE = 2'd2;
  localparam logic [1:0] MODE_VHDR = 2'd3;

  localparam logic [15:0] UNKNOWN_ID = 16'd1;
  localparam logic [15:0] PAD_ID     = 16'd0;
  localparam logic [15:0] NUM_ID_RST = 16'd1;

  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  text_byte;
    logic [7:0]  entry_index;
    logic [4:0]  byte_pos;
    logic [15:0] entry_id;
    logic [4:0]  word_length;
  } item_t;

  typedef struct packed {
    logic [15:0] token_id;
    logic [3:0]  slot;
    logic        last;
    logic [3:0]  token_count;
  } token_t;

  // Vocabulary write request from the controller
  typedef struct packed {
    logic        byte_we;
    logic        hdr_we;
    logic [7:0]  entry;
    logic [4:0]  pos;
    logic [7:0]  data;
    logic [15:0] id;
    logic [4:0]  len;
  } vwr_t;

  typedef struct packed {
    logic [15:0] id;
    logic [4:0]  len;
  } vhdr_t;

endpackage

// File: hw/rtl/wtvm_vocab.sv
`timescale 1ns / 1ps
// Vocabulary storage: word rows and entry headers, one read port each.
// Depends on wtvm_pkg.
module wtvm_vocab import wtvm_pkg::*; #(
  parameter int VOCAB_ENTRIES     = VOCAB_ENTRIES_DEF,
  parameter int WORD_BUFFER_BYTES = WORD_BUFFER_BYTES_DEF,
  localparam int WMAX = WORD_BUFFER_BYTES - 1,
  localparam int EW   = (VOCAB_ENTRIES > 1) ? $clog2(VOCAB_ENTRIES) : 1,
  localparam int PW   = (WMAX > 1) ? $clog2(WMAX) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  vwr_t                     wr,
  input  logic                     rd_en,
  input  logic [EW-1:0]            rd_addr,
  output vhdr_t                    rd_hdr,
  output logic [WMAX-1:0][7:0]     rd_row,
  output logic                     clearing
);

  logic [WMAX-1:0][7:0] row_mem [VOCAB_ENTRIES];
  vhdr_t                hdr_mem [VOCAB_ENTRIES];
  logic [EW-1:0]        clr_idx;

  // Sweep the headers to empty after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (int'(clr_idx) == VOCAB_ENTRIES - 1) clearing <= 1'b0;
    end
  end

  // Header memory
  always_ff @(posedge clk) begin
    if (clearing) begin
      hdr_mem[clr_idx] <= '0;
    end else if (wr.hdr_we) begin
      hdr_mem[EW'(wr.entry)] <= '{id: wr.id, len: wr.len};
    end
    if (rd_en) rd_hdr <= hdr_mem[rd_addr];
  end

  // Word row memory, one byte lane written at a time
  always_ff @(posedge clk) begin
    if (wr.byte_we) row_mem[EW'(wr.entry)][PW'(wr.pos)] <= wr.data;
    if (rd_en) rd_row <= row_mem[rd_addr];
  end

endmodule

// File: hw/rtl/wtvm_word_buf.sv
`timescale 1ns / 1ps
// Pending word buffer and its compare against one vocabulary row.
// Depends on wtvm_pkg.
module wtvm_word_buf import wtvm_pkg::*; #(
  parameter int WORD_BUFFER_BYTES = WORD_BUFFER_BYTES_DEF,
  localparam int WMAX = WORD_BUFFER_BYTES - 1,
  localparam int LW   = $clog2(WORD_BUFFER_BYTES),
  localparam int PW   = (WMAX > 1) ? $clog2(WMAX) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [7:0]           push_byte,
  input  logic                 push_digit,
  input  logic                 clear,
  input  vhdr_t                row_hdr,
  input  logic [WMAX-1:0][7:0] row,
  output logic [LW-1:0]        len,
  output logic                 all_digits,
  output logic                 match
);

  logic [7:0] wbytes [WMAX];
  logic       bytes_eq;

  // Append or drop the word
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      len        <= '0;
      all_digits <= 1'b1;
    end else if (push) begin
      len <= len + 1'b1;
      if (!push_digit) all_digits <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !clear) wbytes[PW'(len)] <= push_byte;
  end

  // Compare the bytes in use, ignore the rest
  always_comb begin
    bytes_eq = 1'b1;
    for (int k = 0; k < WMAX; k++) begin
      if (k < int'(len) && wbytes[k] != row[k]) bytes_eq = 1'b0;
    end
    match = bytes_eq && (row_hdr.len != 5'd0) && (int'(row_hdr.len) == int'(len));
  end

endmodule

// File: hw/rtl/word_tokenizer_vocab_match.sv
`timescale 1ns / 1ps
// Word tokenizer: text bytes in, token ids out, vocabulary matched by a scan of the
// entry memory. A word ending that is not all digits scans the vocabulary one entry
// per cycle through the memory read port, stopping at the first match; then the
// token is handed over when the output is free. End of text gives one token per
// cycle up to MAX_TOKENS while the output is not stalled. After reset the header
// memory is swept empty, during which no item is taken. Depends on wtvm_pkg,
// wtvm_vocab, wtvm_word_buf.
`include "assert_macros.svh"
module word_tokenizer_vocab_match import wtvm_pkg::*; #(
  parameter int VOCAB_ENTRIES     = VOCAB_ENTRIES_DEF,
  parameter int MAX_TOKENS        = MAX_TOKENS_DEF,
  parameter int WORD_BUFFER_BYTES = WORD_BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        token_valid,
  input  logic        token_stall,
  output token_t      token,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int WMAX = WORD_BUFFER_BYTES - 1;
  localparam int EW   = (VOCAB_ENTRIES > 1) ? $clog2(VOCAB_ENTRIES) : 1;
  localparam int LW   = $clog2(WORD_BUFFER_BYTES);
  localparam int TW   = $clog2(MAX_TOKENS + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WORD  = 3'd3;
  localparam logic [2:0] S_PAD   = 3'd4;

  logic [2:0]    state;
  logic [15:0]   num_token_id;
  logic [TW-1:0] tokens;
  logic          seq_full;
  logic          flush;
  logic [TW-1:0] real_cnt;
  logic [15:0]   word_id;
  logic [EW:0]   scan_idx;
  logic          chk_v;
  logic          chk_last;

  logic                 accept;
  logic                 out_free;
  logic                 emit;
  logic                 fin;
  logic [7:0]           ch;
  logic                 is_digit;
  logic                 is_word_ch;
  vwr_t                 vwr;
  logic                 entry_ok;
  logic                 rd_en;
  vhdr_t                rd_hdr;
  logic [WMAX-1:0][7:0] rd_row;
  logic                 clearing;
  logic                 push;
  logic                 wclear;
  logic [LW-1:0]        wlen;
  logic                 all_digits;
  logic                 match;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;
  assign out_free   = !token_valid || !token_stall;
  assign emit       = ((state == S_WORD) || (state == S_PAD)) && out_free;
  assign fin        = (int'(tokens) + 1 >= MAX_TOKENS);

  // Fold case and classify the text byte
  always_comb begin
    ch = item.text_byte;
    if (item.text_byte inside {[CH_UA:CH_UZ]}) ch = item.text_byte + CASE_OFS;
    is_digit   = ch inside {[CH_0:CH_9]};
    is_word_ch = is_digit || (ch inside {[CH_LA:CH_LZ]});
  end

  // Vocabulary loads
  always_comb begin
    entry_ok    = (int'(item.entry_index) < VOCAB_ENTRIES);
    vwr.byte_we = accept && entry_ok && (item.mode == MODE_VBYTE) &&
                  (int'(item.byte_pos) < WMAX);
    vwr.hdr_we  = accept && entry_ok && (item.mode == MODE_VHDR);
    vwr.entry   = item.entry_index;
    vwr.pos     = item.byte_pos;
    vwr.data    = item.text_byte;
    vwr.id      = item.entry_id;
    vwr.len     = item.word_length;
  end

  assign push   = accept && (item.mode == MODE_TEXT) && !seq_full && is_word_ch &&
                  (int'(wlen) < WMAX);
  assign wclear = (state == S_WORD && out_free) ||
                  (accept && item.mode == MODE_EOT && seq_full);
  assign rd_en  = (state == S_SCAN) && (int'(scan_idx) < VOCAB_ENTRIES);

  wtvm_vocab #(
    .VOCAB_ENTRIES     (VOCAB_ENTRIES),
    .WORD_BUFFER_BYTES (WORD_BUFFER_BYTES)
  ) u_vocab (
    .clk      (clk),
    .rst      (rst),
    .wr       (vwr),
    .rd_en    (rd_en),
    .rd_addr  (scan_idx[EW-1:0]),
    .rd_hdr   (rd_hdr),
    .rd_row   (rd_row),
    .clearing (clearing)
  );

  wtvm_word_buf #(
    .WORD_BUFFER_BYTES (WORD_BUFFER_BYTES)
  ) u_word (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_byte  (ch),
    .push_digit (is_digit),
    .clear      (wclear),
    .row_hdr    (rd_hdr),
    .row        (rd_row),
    .len        (wlen),
    .all_digits (all_digits),
    .match      (match)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_token_id <= NUM_ID_RST;
    end else if (cfg_valid && cfg_ready) begin
      num_token_id <= cfg_data;
    end
  end

  // Output valid: raise on a new token, drop after its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (emit) begin
      token_valid <= 1'b1;
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      tokens      <= '0;
      seq_full    <= 1'b0;
      flush       <= 1'b0;
      chk_v       <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (!clearing) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            if (item.mode == MODE_TEXT && !seq_full && !push && int'(wlen) > 0) begin
              // word ended by a separator or a full buffer
              flush <= 1'b0;
              if (all_digits) begin
                word_id <= num_token_id;
                state   <= S_WORD;
              end else begin
                scan_idx <= '0;
                chk_v    <= 1'b0;
                state    <= S_SCAN;
              end
            end else if (item.mode == MODE_EOT) begin
              if (seq_full) begin
                tokens   <= '0;
                seq_full <= 1'b0;
              end else if (int'(wlen) > 0) begin
                flush <= 1'b1;
                if (all_digits) begin
                  word_id <= num_token_id;
                  state   <= S_WORD;
                end else begin
                  scan_idx <= '0;
                  chk_v    <= 1'b0;
                  state    <= S_SCAN;
                end
              end else begin
                real_cnt <= tokens;
                state    <= S_PAD;
              end
            end
          end
        end
        S_SCAN: begin
          // one entry read per cycle, compared the cycle after
          chk_v    <= rd_en;
          chk_last <= (int'(scan_idx) == VOCAB_ENTRIES - 1);
          if (rd_en) scan_idx <= scan_idx + 1'b1;
          if (chk_v && match) begin
            word_id <= rd_hdr.id;
            state   <= S_WORD;
          end else if (chk_v && chk_last) begin
            word_id <= UNKNOWN_ID;
            state   <= S_WORD;
          end
        end
        S_WORD: begin
          if (out_free) begin
            token.token_id    <= word_id;
            token.slot        <= 4'(tokens);
            token.last        <= fin;
            token.token_count <= fin ? 4'(int'(tokens) + 1) : 4'd0;
            if (fin) begin
              state <= S_IDLE;
              if (flush) begin
                tokens   <= '0;
                seq_full <= 1'b0;
              end else begin
                tokens   <= tokens + 1'b1;
                seq_full <= 1'b1;
              end
            end else begin
              tokens <= tokens + 1'b1;
              if (flush) begin
                real_cnt <= tokens + 1'b1;
                state    <= S_PAD;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        S_PAD: begin
          if (out_free) begin
            token.token_id    <= PAD_ID;
            token.slot        <= 4'(tokens);
            token.last        <= fin;
            token.token_count <= fin ? 4'(real_cnt) : 4'd0;
            if (fin) begin
              tokens   <= '0;
              seq_full <= 1'b0;
              state    <= S_IDLE;
            end else begin
              tokens <= tokens + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMP(a_last_slot, token_valid && token.last, int'(token.slot) == (MAX_TOKENS - 1) % 16)
  `ASSERT_IMP(a_count_on_last, token_valid && !token.last, token.token_count == 4'd0)
  `ASSERT_IMP(a_busy_scan, state == S_SCAN, item_stall)
  `ASSERT_NXT(a_word_done, state == S_WORD && out_free, token_valid && wlen == '0)

endmodule
